FILE: sv/ogne_pkg.sv
// ----------------------------------------------------------------------------
// ogne_pkg
// Shared types, constants and helpers of the occupancy grid neighbor engine.
// ----------------------------------------------------------------------------
package ogne_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 7;   // width of the dimension registers
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAG_EN     = 2'd2;

  typedef enum logic [1:0] {
    REQ_BLOCK   = 2'd0,
    REQ_UNBLOCK = 2'd1,
    REQ_LOAD    = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t        req_type;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [2:0]       byte_index;
    logic [7:0]       octet;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [COL_W-1:0] nbr_col;
    logic [ROW_W-1:0] nbr_row;
    logic             last;
  } rsp_t;

  // which row the datapath reads
  typedef enum logic [1:0] {
    RD_SEL_IN  = 2'd0,
    RD_SEL_DN  = 2'd1,
    RD_SEL_MID = 2'd2
  } rd_sel_t;

  // which result the datapath launches
  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_ERR  = 2'd1,
    EM_DONE = 2'd2,
    EM_PICK = 2'd3
  } emit_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_up;
    logic    cap_dn;
    logic    build_mask;
    logic    write_back;
    emit_t   emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_query;
    logic mask_zero;
    logic mask_one;
  } dp_sts_t;

  // neighbor offsets, modulo 2**DIM_W; diagonals first, then up, down, left, right
  function automatic logic [DIM_W-1:0] dir_dcol(input logic [2:0] i);
    logic [DIM_W-1:0] d;
    case (i)
      3'd0, 3'd1, 3'd7: d = DIM_W'(1);
      3'd2, 3'd3, 3'd6: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [DIM_W-1:0] dir_drow(input logic [2:0] i);
    logic [DIM_W-1:0] d;
    case (i)
      3'd0, 3'd3, 3'd4: d = DIM_W'(1);
      3'd1, 3'd2, 3'd5: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/occupancy_grid_neighbor_engine.sv
// ----------------------------------------------------------------------------
// occupancy_grid_neighbor_engine
// One blocked bit per grid cell with cell updates, row byte loads and
// neighbor queries.
// ----------------------------------------------------------------------------
// a request is taken at a clock edge with start high and busy low; each
// result shows on out_data for one cycle with out_strobe high and cannot be
// held off. block, unblock and load do a read-modify-write of one row: busy
// is high for one cycle and the single acknowledge beat is registered in the
// write-back state; no new request is taken until busy falls. a neighbor
// query reads the rows above, below and at the cell from the row store (one
// read port, one row per cycle), then sends one beat per unblocked in-bounds
// neighbor (diagonals only when enabled), one per cycle, or a single final
// beat if there is none, with busy high throughout. an out-of-range
// request answers with a single error beat. the store is empty after reset
// with no clearing pass: per-row valid bits make never written rows read as
// unblocked. configuration writes take effect at once and are meant for
// idle periods
module occupancy_grid_neighbor_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  ogne_pkg::req_t                 in_data,
  // result channel
  output logic                           out_strobe,
  output ogne_pkg::rsp_t                 out_data,
  // configuration
  input  logic                           cfg_we,
  input  logic [ogne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogne_pkg::DIM_W-1:0]     cfg_data
);

  ogne_pkg::ctl_cmd_t cmd;
  ogne_pkg::dp_sts_t  sts;

  // sequencer
  ogne_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // row store, neighbor mask and result register
  ogne_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

FILE: sv/ogne_ram.sv
// ----------------------------------------------------------------------------
// ogne_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ogne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/ogne_ctrl.sv
// ----------------------------------------------------------------------------
// ogne_ctrl
// Request sequencer: read-modify-write for updates, three row reads and
// one result per cycle for neighbor queries, an error beat when out of range.
// ----------------------------------------------------------------------------
module ogne_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ogne_pkg::dp_sts_t  sts,
  output ogne_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_RMW,
    S_RD_DN,
    S_RD_MID,
    S_MASK,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = ogne_pkg::RD_SEL_IN;
    cmd.emit       = ogne_pkg::EM_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cmd.rd_en   = 1'b1;
          if (!sts.in_range) begin
            state_nxt = S_ERR;
          end else if (sts.is_query) begin
            state_nxt = S_RD_DN;
          end else begin
            state_nxt = S_RMW;
          end
        end
      end
      S_ERR: begin
        cmd.emit  = ogne_pkg::EM_ERR;
        state_nxt = S_IDLE;
      end
      S_RMW: begin
        cmd.write_back = 1'b1;
        cmd.emit       = ogne_pkg::EM_DONE;
        state_nxt      = S_IDLE;
      end
      S_RD_DN: begin
        cmd.cap_up = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ogne_pkg::RD_SEL_DN;
        state_nxt  = S_RD_MID;
      end
      S_RD_MID: begin
        cmd.cap_dn = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ogne_pkg::RD_SEL_MID;
        state_nxt  = S_MASK;
      end
      S_MASK: begin
        cmd.build_mask = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (sts.mask_zero) begin
          cmd.emit  = ogne_pkg::EM_DONE;
          state_nxt = S_IDLE;
        end else begin
          cmd.emit = ogne_pkg::EM_PICK;
          if (sts.mask_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: sv/ogne_dp.sv
// ----------------------------------------------------------------------------
// ogne_dp
// Datapath: configuration, row store with per-row valid bits, neighbor
// mask and the result register.
// ----------------------------------------------------------------------------
module ogne_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ogne_pkg::req_t                       in_data,
  input  logic                                 cfg_we,
  input  logic [ogne_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ogne_pkg::DIM_W-1:0]           cfg_data,
  input  ogne_pkg::ctl_cmd_t                   cmd,
  output ogne_pkg::dp_sts_t                    sts,
  output logic                                 out_strobe,
  output ogne_pkg::rsp_t                       out_data
);

  logic [ogne_pkg::DIM_W-1:0]    grid_width_r, grid_height_r;
  logic                          diag_en_r;
  logic [ogne_pkg::DIM_W-1:0]    eff_w, eff_h;

  ogne_pkg::req_t                req_r;
  logic [ogne_pkg::ROW_W-1:0]    rd_addr, rd_addr_r;
  logic [ogne_pkg::MAX_ROWS-1:0] row_vld_r;
  logic [ogne_pkg::MAX_COLS-1:0] ram_q, row_q, up_r, dn_r, new_row, sel_row;
  logic [7:0]                    mask_r, mask_nxt;
  logic [2:0]                    pick;
  logic                          out_strobe_r;
  ogne_pkg::rsp_t                out_data_r, out_data_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= ogne_pkg::DIM_W'(ogne_pkg::MAX_COLS);
      grid_height_r <= ogne_pkg::DIM_W'(ogne_pkg::MAX_ROWS);
      diag_en_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ogne_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        ogne_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        ogne_pkg::CFG_DIAG_EN:     diag_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign eff_w = (grid_width_r > ogne_pkg::DIM_W'(ogne_pkg::MAX_COLS)) ?
                 ogne_pkg::DIM_W'(ogne_pkg::MAX_COLS) : grid_width_r;
  assign eff_h = (grid_height_r > ogne_pkg::DIM_W'(ogne_pkg::MAX_ROWS)) ?
                 ogne_pkg::DIM_W'(ogne_pkg::MAX_ROWS) : grid_height_r;

  // range check of the incoming request; a load only needs its row and a nonzero width
  always_comb begin
    sts.is_query = (in_data.req_type == ogne_pkg::REQ_QUERY);
    sts.in_range = ({1'b0, in_data.row} < eff_h) &&
                   ((in_data.req_type == ogne_pkg::REQ_LOAD) ? (eff_w != '0) :
                    ({1'b0, in_data.col} < eff_w));
    sts.mask_zero = (mask_r == '0);
    sts.mask_one  = (mask_r != '0) && ((mask_r & (mask_r - 8'd1)) == '0);
  end

  // read address: the query starts one row up, updates read their own row
  always_comb begin
    case (cmd.rd_sel)
      ogne_pkg::RD_SEL_DN:  rd_addr = req_r.row - ogne_pkg::ROW_W'(1);
      ogne_pkg::RD_SEL_MID: rd_addr = req_r.row;
      default: begin
        rd_addr = (in_data.req_type == ogne_pkg::REQ_QUERY) ?
                  in_data.row + ogne_pkg::ROW_W'(1) : in_data.row;
      end
    endcase
  end

  ogne_ram #(
    .WIDTH (ogne_pkg::MAX_COLS),
    .DEPTH (ogne_pkg::MAX_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write_back),
    .waddr (req_r.row),
    .wdata (new_row),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // a row never written reads as all unblocked
  assign row_q = row_vld_r[rd_addr_r] ? ram_q : '0;

  always_comb begin
    new_row = row_q;
    for (int j = 0; j < ogne_pkg::MAX_COLS; j++) begin
      if (req_r.req_type == ogne_pkg::REQ_LOAD) begin
        if ((ogne_pkg::COL_W'(j) >> 3) == ogne_pkg::COL_W'(req_r.byte_index) &&
            ogne_pkg::DIM_W'(j) < eff_w) begin
          new_row[j] = req_r.octet[j % 8];
        end
      end else if (ogne_pkg::COL_W'(j) == req_r.col) begin
        new_row[j] = (req_r.req_type == ogne_pkg::REQ_BLOCK);
      end
    end
  end

  // candidate neighbors, bit i in reporting order
  always_comb begin
    logic [ogne_pkg::DIM_W-1:0] nc, nr, dr;
    mask_nxt = '0;
    sel_row  = '0;
    nc       = '0;
    nr       = '0;
    dr       = '0;
    for (int i = 0; i < 8; i++) begin
      dr = ogne_pkg::dir_drow(3'(i));
      nc = {1'b0, req_r.col} + ogne_pkg::dir_dcol(3'(i));
      nr = {1'b0, req_r.row} + dr;
      if (dr == ogne_pkg::DIM_W'(1)) begin
        sel_row = up_r;
      end else if (dr == '0) begin
        sel_row = row_q;
      end else begin
        sel_row = dn_r;
      end
      mask_nxt[i] = (nc < eff_w) && (nr < eff_h) &&
                    !sel_row[nc[ogne_pkg::COL_W-1:0]] && (diag_en_r || i >= 4);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.rd_en) begin
      rd_addr_r <= rd_addr;
    end
    if (cmd.cap_up) begin
      up_r <= row_q;
    end
    if (cmd.cap_dn) begin
      dn_r <= row_q;
    end
    if (cmd.build_mask) begin
      mask_r <= mask_nxt;
    end else if (cmd.emit == ogne_pkg::EM_PICK) begin
      mask_r <= mask_r & (mask_r - 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.write_back) begin
      row_vld_r[req_r.row] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.emit != ogne_pkg::EM_IDLE);
    end
  end

  always_comb begin
    out_data_nxt = '0;
    case (cmd.emit)
      ogne_pkg::EM_ERR: begin
        out_data_nxt.status = 1'b1;
        out_data_nxt.last   = 1'b1;
      end
      ogne_pkg::EM_DONE: begin
        out_data_nxt.last = 1'b1;
      end
      ogne_pkg::EM_PICK: begin
        out_data_nxt.found   = 1'b1;
        out_data_nxt.nbr_col = ogne_pkg::COL_W'({1'b0, req_r.col} +
                                                ogne_pkg::dir_dcol(pick));
        out_data_nxt.nbr_row = ogne_pkg::ROW_W'({1'b0, req_r.row} +
                                                ogne_pkg::dir_drow(pick));
        out_data_nxt.last    = sts.mask_one;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: sv/ogne_checker.sv
// ----------------------------------------------------------------------------
// ogne_checker
// Port-level checks of the occupancy grid neighbor engine.
// ----------------------------------------------------------------------------
module ogne_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input ogne_pkg::req_t                 in_data,
  input logic                           out_strobe,
  input ogne_pkg::rsp_t                 out_data
);

  // an accepted request keeps the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after an accepted request");

  // accepted non-query requests answer with one final beat as busy falls
  a_update_ack: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.req_type != ogne_pkg::REQ_QUERY
    |=> ##1 (out_strobe && out_data.last))
    else $error("update acknowledge missing");

  // a beat without a neighbor ends its request
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.found |-> out_data.last)
    else $error("beat without neighbor not marked last");

  // error beats carry no neighbor
  a_err_no_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status |-> !out_data.found)
    else $error("error beat carries a neighbor");

  // the final beat of a request is followed by a gap
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last |=> !out_strobe)
    else $error("beat right after a final beat");

endmodule

bind occupancy_grid_neighbor_engine ogne_checker u_ogne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
